[sv/ist_pkg.sv]
package ist_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int TOTAL_W   = 36;
  localparam int CAP_W     = 5;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_READ    = 3'd3,
    ACT_WRITE   = 3'd4,
    ACT_REVERSE = 3'd5,
    ACT_SHL     = 3'd6,
    ACT_NONE    = 3'd7
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // Control from the sequencer to the reduction unit
  typedef struct packed {
    logic en;
    logic first;
  } red_ctl_t;

endpackage

[sv/ist_ram.sv]
module ist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ist_reduce.sv]
module ist_reduce import ist_pkg::*; (
  input  logic                      clk,
  input  red_ctl_t                  ctl,
  input  logic signed [WORD_W-1:0]  din,
  output logic signed [WORD_W-1:0]  mx,
  output logic signed [WORD_W-1:0]  mn,
  output logic signed [TOTAL_W-1:0] sum
);

  logic signed [TOTAL_W-1:0] din_ext;

  assign din_ext = {{(TOTAL_W-WORD_W){din[WORD_W-1]}}, din};

  // First word seeds all three; later words compare and accumulate
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.first) begin
        mx  <= din;
        mn  <= din;
        sum <= din_ext;
      end else begin
        if (din > mx) begin
          mx <= din;
        end
        if (din < mn) begin
          mn <= din;
        end
        sum <= sum + din_ext;
      end
    end
  end

endmodule

[sv/indexed_shift_array_table_unit.sv]
// Sequence: refused requests, the unused action and short reverses go straight to the scan; append and write
//   put one word, read fetches a slot, insert moves any slots up then puts, delete fetches then moves any
//   slots down, shift left moves slots down then clears the last, and reverse reads low, reads high, writes
//   low and writes high per swapped pair; all end with the scan. One transaction at a time, the next is
//   accepted the cycle after the result loads; the shared max/min/sum unit scans one slot per cycle.
// Reset (synchronous, rst high): table empty, capacity 16, no output pending; RAM not cleared.
module indexed_shift_array_table_unit import ist_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CAP_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic [POS_W-1:0]          position,
  input  logic signed [WORD_W-1:0]  word_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORD_W-1:0]  word_out,
  output logic [STAT_W-1:0]         status,
  output logic [CNT_W-1:0]          count,
  output logic signed [WORD_W-1:0]  largest,
  output logic signed [WORD_W-1:0]  smallest,
  output logic signed [TOTAL_W-1:0] total
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  // Compare width wide enough for the count, the 5-bit capacity and the 4-bit position fields
  localparam int KW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_FETCH   = 13'b0000000000010,
    S_CAPTURE = 13'b0000000000100,
    S_MV_RD   = 13'b0000000001000,
    S_MV_WR   = 13'b0000000010000,
    S_PUT     = 13'b0000000100000,
    S_CLEAR   = 13'b0000001000000,
    S_RV_RDLO = 13'b0000010000000,
    S_RV_RDHI = 13'b0000100000000,
    S_RV_WRLO = 13'b0001000000000,
    S_RV_WRHI = 13'b0010000000000,
    S_SCAN    = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } seq_state_t;

  seq_state_t state;

  // Sequencer control
  logic [CW-1:0]    live_count;
  logic [CAP_W-1:0] capacity;
  act_t             act;
  logic [IW-1:0]    pos;
  logic [IW-1:0]    src;
  logic [IW-1:0]    dst;
  logic [IW-1:0]    put_addr;
  logic [CW-1:0]    moves;
  logic             move_up;
  logic [IW:0]      lo;
  logic [IW:0]      hi;
  logic [CW-1:0]    scan_idx;
  logic             scan_pend;
  logic             scan_first;
  logic [STAT_W-1:0] stat;

  // Payload
  logic signed [WORD_W-1:0] word;
  logic signed [WORD_W-1:0] result;
  logic signed [WORD_W-1:0] hold;

  // RAM port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Reduction unit
  red_ctl_t                  red_ctl;
  logic signed [WORD_W-1:0]  red_mx;
  logic signed [WORD_W-1:0]  red_mn;
  logic signed [TOTAL_W-1:0] red_sum;

  // Request checks against the count before the step
  logic [KW-1:0] n_k;
  logic [KW-1:0] p_k;
  logic [KW-1:0] cap_k;
  logic [KW-1:0] lim_k;
  logic          full;
  logic          scan_issue;
  logic          out_load;

  assign n_k   = KW'(live_count);
  assign p_k   = KW'(position);
  assign cap_k = KW'(capacity);
  assign lim_k = (cap_k > KW'(SLOTS)) ? KW'(SLOTS) : cap_k;
  assign full  = (n_k >= lim_k);

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == S_IDLE);
  assign scan_issue = (state == S_SCAN) && (scan_idx < live_count);
  // Load the output register once the previous result has gone
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  // RAM address and data selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst;
    ram_wdata = ram_rdata;
    ram_raddr = src;
    case (state)
      S_FETCH: begin
        ram_raddr = pos;
      end
      S_MV_RD: begin
        ram_raddr = src;
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst;
        ram_wdata = ram_rdata;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_addr;
        ram_wdata = word;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = put_addr;
        ram_wdata = '0;
      end
      S_RV_RDLO: begin
        ram_raddr = lo[IW-1:0];
      end
      S_RV_RDHI: begin
        ram_raddr = hi[IW-1:0];
      end
      S_RV_WRLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_RV_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi[IW-1:0];
        ram_wdata = hold;
      end
      S_SCAN: begin
        ram_raddr = scan_idx[IW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign red_ctl.en    = scan_pend;
  assign red_ctl.first = scan_first;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      capacity   <= CAP_RESET;
      act        <= ACT_NONE;
      pos        <= '0;
      src        <= '0;
      dst        <= '0;
      put_addr   <= '0;
      moves      <= '0;
      move_up    <= 1'b0;
      lo         <= '0;
      hi         <= '0;
      scan_idx   <= '0;
      scan_pend  <= 1'b0;
      scan_first <= 1'b0;
      stat       <= ST_DONE;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          scan_idx  <= '0;
          scan_pend <= 1'b0;
          if (in_valid) begin
            act <= act_t'(action);
            pos <= IW'(position);
            case (act_t'(action))
              ACT_APPEND: begin
                if (full) begin
                  stat  <= ST_FULL;
                  state <= S_SCAN;
                end else begin
                  stat       <= ST_DONE;
                  put_addr   <= IW'(live_count);
                  live_count <= live_count + CW'(1);
                  state      <= S_PUT;
                end
              end
              ACT_INSERT: begin
                if (p_k > n_k) begin
                  stat  <= ST_RANGE;
                  state <= S_SCAN;
                end else if (full) begin
                  stat  <= ST_FULL;
                  state <= S_SCAN;
                end else begin
                  stat       <= ST_DONE;
                  put_addr   <= IW'(position);
                  src        <= IW'(live_count - CW'(1));
                  dst        <= IW'(live_count);
                  move_up    <= 1'b1;
                  moves      <= live_count - CW'(position);
                  live_count <= live_count + CW'(1);
                  state      <= (p_k == n_k) ? S_PUT : S_MV_RD;
                end
              end
              ACT_DELETE: begin
                if (p_k >= n_k) begin
                  stat  <= ST_RANGE;
                  state <= S_SCAN;
                end else begin
                  stat       <= ST_DONE;
                  src        <= IW'(position) + IW'(1);
                  dst        <= IW'(position);
                  move_up    <= 1'b0;
                  moves      <= live_count - CW'(1) - CW'(position);
                  live_count <= live_count - CW'(1);
                  state      <= S_FETCH;
                end
              end
              ACT_READ: begin
                if (p_k >= n_k) begin
                  stat  <= ST_RANGE;
                  state <= S_SCAN;
                end else begin
                  stat  <= ST_DONE;
                  state <= S_FETCH;
                end
              end
              ACT_WRITE: begin
                if (p_k >= n_k) begin
                  stat  <= ST_RANGE;
                  state <= S_SCAN;
                end else begin
                  stat     <= ST_DONE;
                  put_addr <= IW'(position);
                  state    <= S_PUT;
                end
              end
              ACT_REVERSE: begin
                stat <= ST_DONE;
                if (n_k > KW'(1)) begin
                  lo    <= '0;
                  hi    <= (IW+1)'(live_count - CW'(1));
                  state <= S_RV_RDLO;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_SHL: begin
                stat <= ST_DONE;
                if (n_k != '0) begin
                  src      <= IW'(1);
                  dst      <= '0;
                  move_up  <= 1'b0;
                  moves    <= live_count - CW'(1);
                  put_addr <= IW'(live_count - CW'(1));
                  state    <= (n_k == KW'(1)) ? S_CLEAR : S_MV_RD;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                stat  <= ST_DONE;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          // Delete goes on to close the gap unless it removed the last entry
          if (act == ACT_DELETE && moves != '0) begin
            state <= S_MV_RD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          moves <= moves - CW'(1);
          if (move_up) begin
            src <= src - IW'(1);
            dst <= dst - IW'(1);
          end else begin
            src <= src + IW'(1);
            dst <= dst + IW'(1);
          end
          if (moves == CW'(1)) begin
            case (act)
              ACT_INSERT: state <= S_PUT;
              ACT_SHL:    state <= S_CLEAR;
              default:    state <= S_SCAN;
            endcase
          end else begin
            state <= S_MV_RD;
          end
        end
        S_PUT: begin
          state <= S_SCAN;
        end
        S_CLEAR: begin
          state <= S_SCAN;
        end
        S_RV_RDLO: begin
          state <= S_RV_RDHI;
        end
        S_RV_RDHI: begin
          state <= S_RV_WRLO;
        end
        S_RV_WRLO: begin
          state <= S_RV_WRHI;
        end
        S_RV_WRHI: begin
          lo <= lo + (IW+1)'(1);
          hi <= hi - (IW+1)'(1);
          // Another pair remains while the next low index stays below the next high
          if (lo + (IW+1)'(2) < hi) begin
            state <= S_RV_RDLO;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_pend  <= scan_issue;
          scan_first <= scan_issue && (scan_idx == '0);
          if (scan_issue) begin
            scan_idx <= scan_idx + CW'(1);
          end else if (!scan_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      word   <= word_in;
      result <= '0;
    end
    if (state == S_CAPTURE) begin
      result <= ram_rdata;
    end
    if (state == S_RV_RDHI) begin
      hold <= ram_rdata;
    end
    if (out_load) begin
      word_out <= result;
      status   <= stat;
      count    <= CNT_W'(live_count);
      if (live_count == '0) begin
        largest  <= '0;
        smallest <= '0;
        total    <= '0;
      end else begin
        largest  <= red_mx;
        smallest <= red_mn;
        total    <= red_sum;
      end
    end
  end

  ist_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ist_reduce u_reduce (
    .clk (clk),
    .ctl (red_ctl),
    .din (ram_rdata),
    .mx  (red_mx),
    .mn  (red_mn),
    .sum (red_sum)
  );

endmodule
